[src/all_different_hall_filter_defines.svh]
// Assertion macros for the all-different Hall filter.
// The including module must have i_clk and i_rst_n.
`ifndef ALL_DIFFERENT_HALL_FILTER_DEFINES_SVH
`define ALL_DIFFERENT_HALL_FILTER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define ADHF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ADHF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/adhf_pkg.sv]
// Shared types, constants and helper functions of the all-different Hall filter.
// No dependencies.
package adhf_pkg;

    localparam int MaxDomains = 32;
    localparam int DomainBits = 64;
    localparam int StoreDepth = 32;
    localparam int StoreCap   = (MaxDomains < StoreDepth) ? MaxDomains : StoreDepth;
    localparam int IdxW       = 5;
    localparam int CntW       = 6;
    localparam int PcW        = 7;

    localparam logic [63:0] ValueMask =
        (DomainBits >= 64) ? {64{1'b1}} : ((64'd1 << DomainBits) - 64'd1);

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FAIL = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WT,
        ST_ONE_WT
    } t_state;

    // One entry of the sorting chain.
    typedef struct packed {
        logic            vld;
        logic [PcW-1:0]  pc;
        logic [IdxW-1:0] idx;
        logic [63:0]     bits;
    } t_entry;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic clear;
        logic ins;
        logic shift;
    } t_chain_ctl;

    // Population count of a 64-bit word, summed as a balanced adder tree.
    function automatic logic [PcW-1:0] popcount64(input logic [63:0] v);
        logic [1:0] s2  [32];
        logic [2:0] s4  [16];
        logic [3:0] s8  [8];
        logic [4:0] s16 [4];
        logic [5:0] s32 [2];
        for (int i = 0; i < 32; i++) begin
            s2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s32[i] = {1'b0, s16[2*i]} + {1'b0, s16[2*i+1]};
        end
        return {1'b0, s32[0]} + {1'b0, s32[1]};
    endfunction

endpackage

[src/adhf_if.sv]
// Valid/ready channel interfaces for the all-different Hall filter.
// Depends on nothing.
interface adhf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] domain_bits;
    logic        last;

    modport source (output valid, output domain_bits, output last, input ready);
    modport sink (input valid, input domain_bits, input last, output ready);
endinterface

interface adhf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  domain_index;
    logic [63:0] filtered_bits;
    logic        end_of_set;

    modport source (output valid, output status, output domain_index,
                    output filtered_bits, output end_of_set, input ready);
    modport sink (input valid, input status, input domain_index,
                  input filtered_bits, input end_of_set, output ready);
endinterface

[src/adhf_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module adhf_ram #(
    parameter int Width = 64,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/adhf_cell.sv]
// One cell of the sorting chain: holds one domain, its popcount and load index.
// Depends on adhf_pkg.
module adhf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  adhf_pkg::t_chain_ctl i_ctl,
    input  adhf_pkg::t_entry   i_new,
    input  adhf_pkg::t_entry   i_left,
    input  logic               i_left_gt,
    input  adhf_pkg::t_entry   i_right,
    output adhf_pkg::t_entry   o_entry,
    output logic               o_gt
);
    import adhf_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // This cell yields its place when it is empty or holds a larger count.
    assign o_gt = !r_entry.vld || (r_entry.pc > i_new.pc);

    // Insertion moves larger entries one cell toward the tail; the pass
    // moves the whole row one cell toward the head.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.clear) begin
            n_entry.vld = 1'b0;
        end else if (i_ctl.ins && o_gt) begin
            n_entry = i_left_gt ? i_left : i_new;
        end else if (i_ctl.shift) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.vld <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

[src/adhf_chain.sv]
// Row of sorting cells that keeps domains ordered by popcount, then load index.
// Depends on adhf_pkg and adhf_cell.
module adhf_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adhf_pkg::t_chain_ctl i_ctl,
    input  adhf_pkg::t_entry     i_new,
    output adhf_pkg::t_entry     o_head
);
    import adhf_pkg::*;

    t_entry q   [StoreCap];
    logic   gt  [StoreCap];
    t_entry empty_entry;

    assign empty_entry = '0;

    // Cell zero has no left neighbor; the tail is fed an empty entry.
    for (genvar g = 0; g < StoreCap; g++) begin : g_cell
        adhf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (i_ctl),
            .i_new    (i_new),
            .i_left   ((g == 0) ? empty_entry : q[(g == 0) ? 0 : g - 1]),
            .i_left_gt((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g - 1]),
            .i_right  ((g == StoreCap - 1) ? empty_entry
                                           : q[(g == StoreCap - 1) ? g : g + 1]),
            .o_entry  (q[g]),
            .o_gt     (gt[g])
        );
    end

    assign o_head = q[0];

endmodule

[src/all_different_hall_filter.sv]
// All-different Hall set filter: top level with control and Hall check.
// Depends on adhf_pkg, adhf_if, adhf_chain, adhf_ram and the defines header.
//
// Usage: domains arrive on i_item, one per transfer; the transfer with last
// set closes the set. Each domain is sorted into a row of cells on arrival.
// Up to 32 domains are kept; further ones are dropped and the set then
// reports overflow. After the last item the row is walked head first, one
// domain per cycle, while the Hall set and running union are updated and the
// filtered domains are written to a RAM by load index. On success one result
// per domain follows in load order, each through a RAM read, an output
// register load and a transfer; on failure or overflow a single result with
// end_of_set set is given. i_item is ready only while loading; a stall on
// o_result holds the current result and the block.
// Reset (synchronous, active low) empties the row and returns to loading.
`include "all_different_hall_filter_defines.svh"
module all_different_hall_filter (
    input logic        i_clk,
    input logic        i_rst_n,
    adhf_in_if.sink    i_item,
    adhf_out_if.source o_result
);
    import adhf_pkg::*;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CntW-1:0] r_k, n_k;
    logic [63:0]     r_union, n_union;
    logic [63:0]     r_hall, n_hall;
    logic [CntW-1:0] r_mem, n_mem;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_status, n_status;
    logic [IdxW-1:0] r_index, n_index;
    logic [63:0]     r_fbits, n_fbits;
    logic            r_end, n_end;

    t_chain_ctl      ctl;
    t_entry          new_entry;
    t_entry          head;
    logic            acc;
    logic            store_ok;
    logic            out_take;
    logic [63:0]     in_bits;
    logic [63:0]     v;
    logic [63:0]     u;
    logic [CntW-1:0] m;
    logic [PcW-1:0]  pc;
    logic            ram_we;
    logic [63:0]     ram_rdata;

    assign acc      = i_item.valid && i_item.ready;
    assign out_take = r_out_valid && o_result.ready;
    assign store_ok = r_count < CntW'(StoreCap);
    assign in_bits  = i_item.domain_bits & ValueMask;

    assign new_entry.vld  = 1'b1;
    assign new_entry.pc   = popcount64(in_bits);
    assign new_entry.idx  = r_count[IdxW-1:0];
    assign new_entry.bits = in_bits;

    // Hall step on the head of the row.
    assign v  = head.bits & ~r_hall;
    assign u  = r_union | v;
    assign m  = r_mem + CntW'(1);
    assign pc = popcount64(u);

    adhf_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .i_new  (new_entry),
        .o_head (head)
    );

    adhf_ram #(.Width(64), .Depth(StoreDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(head.idx),
        .i_wdata(v),
        .i_raddr(r_k[IdxW-1:0]),
        .o_rdata(ram_rdata)
    );

    // Next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_union     = r_union;
        n_hall      = r_hall;
        n_mem       = r_mem;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_index     = r_index;
        n_fbits     = r_fbits;
        n_end       = r_end;
        ctl         = '0;
        ram_we      = 1'b0;
        i_item.ready = (r_state == ST_LOAD);

        case (r_state)
            ST_LOAD: begin
                if (acc) begin
                    ctl.ins = store_ok;
                    n_count = r_count + CntW'(store_ok);
                    n_ovf   = r_ovf || !store_ok;
                    if (i_item.last) begin
                        if (r_ovf || !store_ok) begin
                            n_status    = STAT_OVF;
                            n_index     = '0;
                            n_fbits     = '0;
                            n_end       = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = ST_ONE_WT;
                        end else begin
                            n_k     = '0;
                            n_union = '0;
                            n_hall  = '0;
                            n_mem   = '0;
                            n_state = ST_PASS;
                        end
                    end
                end
            end
            ST_PASS: begin
                ram_we    = 1'b1;
                ctl.shift = 1'b1;
                if (v == '0 || pc < PcW'(m)) begin
                    n_status    = STAT_FAIL;
                    n_index     = '0;
                    n_fbits     = '0;
                    n_end       = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_ONE_WT;
                end else begin
                    if (pc == PcW'(m)) begin
                        n_hall  = r_hall | u;
                        n_union = '0;
                        n_mem   = '0;
                    end else begin
                        n_union = u;
                        n_mem   = m;
                    end
                    if (r_k == r_count - CntW'(1)) begin
                        n_k     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_k = r_k + CntW'(1);
                    end
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                n_status    = STAT_OK;
                n_index     = r_k[IdxW-1:0];
                n_fbits     = ram_rdata;
                n_end       = (r_k == r_count - CntW'(1));
                n_out_valid = 1'b1;
                n_state     = ST_EMIT_WT;
            end
            ST_EMIT_WT: begin
                if (out_take) begin
                    n_out_valid = 1'b0;
                    if (r_end) begin
                        ctl.clear = 1'b1;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_state   = ST_LOAD;
                    end else begin
                        n_k     = r_k + CntW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_ONE_WT: begin
                if (out_take) begin
                    n_out_valid = 1'b0;
                    ctl.clear   = 1'b1;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_union     <= '0;
            r_hall      <= '0;
            r_mem       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_union     <= n_union;
            r_hall      <= n_hall;
            r_mem       <= n_mem;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_index  <= n_index;
        r_fbits  <= n_fbits;
        r_end    <= n_end;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_status;
    assign o_result.domain_index  = r_index;
    assign o_result.filtered_bits = r_fbits;
    assign o_result.end_of_set    = r_end;

    // Checks on the control flow.
    `ADHF_ASSERT_NOW(a_load_no_result, r_state == ST_LOAD, !r_out_valid, "result pending while loading")
    `ADHF_ASSERT_NOW(a_pass_in_range, r_state == ST_PASS, r_k < r_count, "pass index beyond loaded count")
    `ADHF_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CntW'(StoreCap), "loaded count above capacity")
    `ADHF_ASSERT_NEXT(a_last_starts_pass, acc && i_item.last && !r_ovf && store_ok, r_state == ST_PASS, "last item did not start the pass")

endmodule

[sim/all_different_hall_filter_tb.sv]
// Testbench for the all-different Hall set filter: directed and random domain sets.
// Depends on adhf_pkg, adhf_if and the all_different_hall_filter RTL.
module all_different_hall_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import adhf_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [4:0]  index;
        logic [63:0] bits;
        logic        eos;
    } t_filter_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    adhf_in_if  in_ch ();
    adhf_out_if out_ch ();

    all_different_hall_filter uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch.sink),
        .o_result (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state for the set being loaded.
    logic [63:0]    set_domains[$];
    logic           set_overflow;
    t_filter_result expected_results[$];

    int  mismatch_count = 0;
    int  result_count = 0;
    int  set_count = 0;
    int  fail_sets = 0;
    int  ovf_sets = 0;
    longint cycle_count = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;

    task automatic report_mismatch(input string what);
        begin
            mismatch_count++;
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic int count_ones(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) n += v[i];
        return n;
    endfunction

    // Predict the results of a closed set: stable popcount order, then Hall walk.
    task automatic predict_set_results();
        int             order[$];
        logic [63:0]    work[$];
        logic [63:0]    hall;
        logic [63:0]    uni;
        int             members;
        int             pc;
        int             j;
        int             cur;
        bit             ok;
        t_filter_result r;
        begin
            set_count++;
            r.index = '0;
            r.bits = '0;
            r.eos = 1'b1;
            if (set_overflow) begin
                ovf_sets++;
                r.status = STAT_OVF;
                expected_results.insert(expected_results.size(), r);
            end else begin
                work = set_domains;
                for (int i = 0; i < work.size(); i++) begin
                    j = order.size();
                    order.insert(order.size(), i);
                    while (j > 0 && count_ones(work[order[j-1]]) > count_ones(work[i])) begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = i;
                end
                hall = '0;
                uni = '0;
                members = 0;
                ok = 1'b1;
                foreach (order[k]) begin
                    cur = order[k];
                    work[cur] = work[cur] & ~hall;
                    if (work[cur] == '0) begin
                        ok = 1'b0;
                        break;
                    end
                    uni |= work[cur];
                    members++;
                    pc = count_ones(uni);
                    if (pc < members) begin
                        ok = 1'b0;
                        break;
                    end
                    if (pc == members) begin
                        hall |= uni;
                        uni = '0;
                        members = 0;
                    end
                end
                if (!ok) begin
                    fail_sets++;
                    r.status = STAT_FAIL;
                    expected_results.insert(expected_results.size(), r);
                end else begin
                    foreach (work[i]) begin
                        r.status = STAT_OK;
                        r.index = 5'(i);
                        r.bits = work[i];
                        r.eos = (i == work.size() - 1);
                        expected_results.insert(expected_results.size(), r);
                    end
                end
            end
            set_domains.delete();
            set_overflow = 1'b0;
        end
    endtask

    // Send one domain; predict on acceptance. The item stays on the bus until
    // the next call replaces it or drops valid at the following falling edge.
    task automatic send_domain(input logic [63:0] bits, input logic last);
        begin
            if (send_idle_on && $urandom_range(0, 3) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.domain_bits <= bits;
            in_ch.last <= last;
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            if (set_domains.size() < StoreCap)
                set_domains.insert(set_domains.size(), bits & ValueMask);
            else set_overflow = 1'b1;
            if (last) predict_set_results();
            @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result has been seen.
    task automatic wait_drained();
        begin
            in_ch.valid <= 1'b0;
            while (expected_results.size() != 0) @(negedge i_clk);
        end
    endtask

    // Random domain: mostly narrow sets over a small value window.
    function automatic logic [63:0] random_domain(input int span, input int base);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < span; i++)
            if ($urandom_range(0, 2) == 0) v[(base + i) % 64] = 1'b1;
        return v;
    endfunction

    // Extremes, the empty domain and single values.
    task automatic test_extremes();
        begin
            send_domain('0, 1'b1);
            send_domain({64{1'b1}}, 1'b1);
            send_domain(64'h8000_0000_0000_0001, 1'b0);
            send_domain(64'h1, 1'b1);
            send_domain(64'h5555_5555_5555_5555, 1'b0);
            send_domain(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        end
    endtask

    // A Hall set forms and trims a wider domain; then a pigeonhole violation.
    task automatic test_hall_sets();
        begin
            send_domain(64'h7, 1'b0);
            send_domain(64'h3, 1'b0);
            send_domain(64'h3, 1'b0);
            send_domain(64'hF, 1'b1);
            send_domain(64'h3, 1'b0);
            send_domain(64'h3, 1'b0);
            send_domain(64'h3, 1'b1);
            send_domain(64'h1, 1'b0);
            send_domain(64'h1, 1'b1);
        end
    endtask

    // Full store of 32, then one too many.
    task automatic test_capacity();
        begin
            for (int i = 0; i < 32; i++)
                send_domain(64'h1 << (63 - i), i == 31);
            for (int i = 0; i < 33; i++)
                send_domain(64'h1 << i, i == 32);
        end
    endtask

    // Random sets; the sender holds off once until the block has drained.
    task automatic test_random_sets(input int items);
        int sent;
        int len;
        int span;
        int base;
        begin
            sent = 0;
            while (sent < items) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34)
                                                  : $urandom_range(1, 8);
                span = $urandom_range(1, 12);
                base = $urandom_range(0, 63);
                for (int i = 0; i < len; i++)
                    send_domain(($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                : random_domain(span, base), i == len - 1);
                sent += len;
                if (sent > items / 3 && sent - len <= items / 3) wait_drained();
                if (sent > items * 3 / 4) begin
                    send_idle_on = 1'b0;
                    recv_idle_on = 1'b0;
                end
            end
        end
    endtask

    // Result checker and receiver stalls.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                t_filter_result e;
                e = expected_results.pop_front();
                if (out_ch.status !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_ch.status, e.status));
                if (out_ch.domain_index !== e.index)
                    report_mismatch($sformatf("domain_index %0d, expected %0d",
                                              out_ch.domain_index, e.index));
                if (out_ch.filtered_bits !== e.bits)
                    report_mismatch($sformatf("filtered_bits %h, expected %h",
                                              out_ch.filtered_bits, e.bits));
                if (out_ch.end_of_set !== e.eos)
                    report_mismatch($sformatf("end_of_set %0b, expected %0b",
                                              out_ch.end_of_set, e.eos));
            end
        end
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        in_ch.valid = 1'b0;
        in_ch.domain_bits = '0;
        in_ch.last = 1'b0;
        set_overflow = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_hall_sets();
        test_capacity();
        test_random_sets(300);
        wait_drained();
        repeat (200) @(negedge i_clk);
        $display("covered %0d sets (%0d failed, %0d overflowed), %0d results checked",
                 set_count, fail_sets, ovf_sets, result_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/adhf_pkg.sv
src/adhf_if.sv
src/adhf_ram.sv
src/adhf_cell.sv
src/adhf_chain.sv
src/all_different_hall_filter.sv
sim/all_different_hall_filter_tb.sv
